>>> rtl/rfr_pkg.sv
// rfr_pkg: shared types, codes and the crc-32 byte update of the response frame receiver
// no dependencies; compiled first

package rfr_pkg;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_SIZE    = 4'd1,
		PH_EXT_LO  = 4'd2,
		PH_EXT_HI  = 4'd3,
		PH_RESP    = 4'd4,
		PH_REMOTE  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CRC     = 4'd7,
		PH_DISCARD = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_TIMEOUT   = 4'd1,
		ST_BAD_FIRST = 4'd2,
		ST_TOO_SMALL = 4'd3,
		ST_BAD_CHAR  = 4'd4,
		ST_WRONG_SIZE = 4'd5,
		ST_CAPACITY  = 4'd6,
		ST_CRC       = 4'd7,
		ST_REMOTE    = 4'd8
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RX_CAPACITY     = 3'd0,
		REG_TIMEOUT_TICKS   = 3'd1,
		REG_EXT_SIZE_CODE   = 3'd2,
		REG_CRC_RESP_CHAR   = 3'd3,
		REG_PLAIN_RESP_CHAR = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] rx_capacity;
		logic [15:0] timeout_ticks;
		logic [6:0]  ext_size_code;
		logic [7:0]  crc_resp_char;
		logic [7:0]  plain_resp_char;
	} cfg_t;

	typedef struct packed {
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        done_res;
		logic [3:0]  status;
		logic [7:0]  remote_error;
		logic [15:0] received_length;
	} res_t;

	// reflected crc-32, one byte, lsb first
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/rfr_in_if.sv
// rfr_in_if: input item channel of the response frame receiver (op and byte)
// depends on nothing

interface rfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] byte_value;

	modport source (output valid, output op, output byte_value, input ready);
	modport sink   (input valid, input op, input byte_value, output ready);
endinterface

>>> rtl/rfr_out_if.sv
// rfr_out_if: result item channel of the response frame receiver
// depends on nothing

interface rfr_out_if;
	logic        valid;
	logic        ready;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        done_res;
	logic [3:0]  status;
	logic [7:0]  remote_error;
	logic [15:0] received_length;

	modport source (output valid, output payload_valid, output payload_byte, output done_res,
		output status, output remote_error, output received_length, input ready);
	modport sink   (input valid, input payload_valid, input payload_byte, input done_res,
		input status, input remote_error, input received_length, output ready);
endinterface

>>> rtl/rfr_cfg.sv
// rfr_cfg: configuration registers written through a plain write port
// depends on rfr_pkg

module rfr_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rfr_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rfr_pkg::CFG_W-1:0]       cfg_wdata,
	output rfr_pkg::cfg_t                   cfg
);
	import rfr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_capacity     <= 16'd0;
			cfg_q.timeout_ticks   <= 16'd1000;
			cfg_q.ext_size_code   <= 7'd127;
			cfg_q.crc_resp_char   <= 8'd254;
			cfg_q.plain_resp_char <= 8'd255;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_RX_CAPACITY:     cfg_q.rx_capacity     <= cfg_wdata;
				REG_TIMEOUT_TICKS:   cfg_q.timeout_ticks   <= cfg_wdata;
				REG_EXT_SIZE_CODE:   cfg_q.ext_size_code   <= cfg_wdata[6:0];
				REG_CRC_RESP_CHAR:   cfg_q.crc_resp_char   <= cfg_wdata[7:0];
				REG_PLAIN_RESP_CHAR: cfg_q.plain_resp_char <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

>>> rtl/rfr_core.sv
// rfr_core: input register, frame state machine, crc check and result register
// depends on rfr_pkg, rfr_in_if, rfr_out_if

module rfr_core (
	input  logic          clk,
	input  logic          arst_n,
	input  rfr_pkg::cfg_t cfg,
	rfr_in_if.sink        rx,
	rfr_out_if.source     result
);
	import rfr_pkg::*;

	// stage 1 input register
	logic       valid_s1;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;

	// frame state
	phase_t      phase_q, phase_d;
	logic [16:0] bytes_left_q, bytes_left_d;
	logic [7:0]  length_low_q, length_low_d;
	logic [31:0] crc_q, crc_d;
	logic [31:0] crc_rx_q, crc_rx_d;
	logic [1:0]  crc_idx_q, crc_idx_d;
	logic [15:0] tick_q, tick_d;
	logic        present_q, present_d;
	logic [3:0]  pend_q, pend_d;
	logic [7:0]  remote_q, remote_d;
	logic [15:0] plen_q, plen_d;

	// result register
	logic res_valid_q;
	res_t res_q, res_d;
	logic emit;

	logic adv;
	logic step;

	// helpers
	logic [31:0] crc_next;
	logic [15:0] tick_inc;
	logic [16:0] bl_dec;
	logic [16:0] take_total;
	logic [16:0] take_hdr;
	logic        do_take;
	logic [16:0] data_w;
	logic [16:0] plen_w;
	logic        do_fail;
	logic [3:0]  fail_st;
	logic [7:0]  fail_rc;
	logic        do_after;
	logic        after_pv;
	logic [7:0]  after_pb;
	logic [3:0]  tmo_st;

	assign adv      = !res_valid_q || result.ready;
	assign rx.ready = !valid_s1 || adv;
	assign step     = valid_s1 && adv;

	assign crc_next = crc32_byte(crc_q, byte_s1);
	assign tick_inc = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
	assign bl_dec   = bytes_left_q - 17'd1;

	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		length_low_d = length_low_q;
		crc_d        = crc_q;
		crc_rx_d     = crc_rx_q;
		crc_idx_d    = crc_idx_q;
		tick_d       = tick_q;
		present_d    = present_q;
		pend_d       = pend_q;
		remote_d     = remote_q;
		plen_d       = plen_q;
		res_d        = '0;
		emit         = 1'b0;
		do_take      = 1'b0;
		take_total   = '0;
		take_hdr     = '0;
		data_w       = '0;
		plen_w       = '0;
		do_fail      = 1'b0;
		fail_st      = ST_OK;
		fail_rc      = 8'd0;
		do_after     = 1'b0;
		after_pv     = 1'b0;
		after_pb     = 8'd0;
		tmo_st       = ST_TIMEOUT;

		if (op_s1 == OP_START) begin
			phase_d      = PH_SIZE;
			bytes_left_d = '0;
			length_low_d = '0;
			crc_d        = CRC_INIT;
			crc_rx_d     = '0;
			crc_idx_d    = '0;
			tick_d       = '0;
			present_d    = 1'b0;
			pend_d       = ST_OK;
			remote_d     = '0;
			plen_d       = '0;
		end else if (phase_q == PH_IDLE || op_s1 == OP_NONE) begin
			// nothing open, or a code with no meaning
		end else if (op_s1 == OP_TICK) begin
			tick_d = tick_inc;
			if (tick_inc >= cfg.timeout_ticks) begin
				tmo_st  = (phase_q == PH_DISCARD) ? pend_q : ST_TIMEOUT;
				phase_d = PH_IDLE;
				emit    = 1'b1;
				res_d.done_res     = 1'b1;
				res_d.status       = tmo_st;
				res_d.remote_error = (tmo_st == ST_REMOTE) ? remote_q : 8'd0;
			end
		end else begin
			unique case (phase_q)
				PH_SIZE: begin
					crc_d = crc_next;
					if (!byte_s1[0]) begin
						bytes_left_d = '0;
						do_fail      = 1'b1;
						fail_st      = ST_BAD_FIRST;
					end else if (byte_s1[7:1] == cfg.ext_size_code) begin
						phase_d = PH_EXT_LO;
					end else begin
						do_take    = 1'b1;
						take_total = {10'd0, byte_s1[7:1]};
						take_hdr   = 17'd1;
					end
				end
				PH_EXT_LO: begin
					crc_d        = crc_next;
					length_low_d = byte_s1;
					phase_d      = PH_EXT_HI;
				end
				PH_EXT_HI: begin
					crc_d      = crc_next;
					do_take    = 1'b1;
					take_total = {1'b0, byte_s1, length_low_q};
					take_hdr   = 17'd3;
				end
				PH_RESP: begin
					crc_d        = crc_next;
					bytes_left_d = bl_dec;
					priority if (byte_s1 == cfg.crc_resp_char) begin
						present_d = 1'b1;
						data_w    = bl_dec - 17'd4;
						if (bl_dec < 17'd4) begin
							do_fail = 1'b1;
							fail_st = ST_TOO_SMALL;
						end
					end else if (byte_s1 == cfg.plain_resp_char) begin
						present_d = 1'b0;
						data_w    = bl_dec;
					end else begin
						do_fail = 1'b1;
						fail_st = ST_BAD_CHAR;
					end
					if (!do_fail) begin
						if (data_w == '0) begin
							if (cfg.rx_capacity != 16'd0) begin
								do_fail = 1'b1;
								fail_st = ST_WRONG_SIZE;
							end else begin
								plen_d   = '0;
								do_after = 1'b1;
							end
						end else begin
							phase_d = PH_REMOTE;
						end
					end
				end
				PH_REMOTE: begin
					crc_d        = crc_next;
					bytes_left_d = bl_dec;
					plen_w       = bl_dec - (present_q ? 17'd4 : 17'd0);
					if (byte_s1 != 8'd0) begin
						do_fail = 1'b1;
						fail_st = ST_REMOTE;
						fail_rc = byte_s1;
					end else if (plen_w > {1'b0, cfg.rx_capacity}) begin
						do_fail = 1'b1;
						fail_st = ST_CAPACITY;
					end else begin
						plen_d = plen_w[15:0];
						if (plen_w == '0) begin
							do_after = 1'b1;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					crc_d        = crc_next;
					bytes_left_d = bl_dec;
					if (bl_dec == (present_q ? 17'd4 : 17'd0)) begin
						do_after = 1'b1;
						after_pv = 1'b1;
						after_pb = byte_s1;
					end else begin
						emit                = 1'b1;
						res_d.payload_valid = 1'b1;
						res_d.payload_byte  = byte_s1;
					end
				end
				PH_CRC: begin
					crc_rx_d = crc_rx_q | ({24'd0, byte_s1} << {crc_idx_q, 3'b000});
					if (bytes_left_q != '0) bytes_left_d = bl_dec;
					if (crc_idx_q != 2'd3) begin
						crc_idx_d = crc_idx_q + 2'd1;
					end else begin
						crc_idx_d      = '0;
						phase_d        = PH_IDLE;
						emit           = 1'b1;
						res_d.done_res = 1'b1;
						if ((crc_q ^ CRC_INIT) != crc_rx_d) begin
							res_d.status = ST_CRC;
						end else begin
							res_d.received_length = plen_q;
						end
					end
				end
				PH_DISCARD: begin
					bytes_left_d = (bytes_left_q != '0) ? bl_dec : bytes_left_q;
					if (bytes_left_d == '0) begin
						phase_d            = PH_IDLE;
						emit               = 1'b1;
						res_d.done_res     = 1'b1;
						res_d.status       = pend_q;
						res_d.remote_error = (pend_q == ST_REMOTE) ? remote_q : 8'd0;
					end
				end
				default: phase_d = PH_IDLE;
			endcase

			// header size check shared by short and extended size
			if (do_take) begin
				if (take_total < take_hdr + 17'd1) begin
					bytes_left_d = '0;
					do_fail      = 1'b1;
					fail_st      = ST_TOO_SMALL;
				end else begin
					bytes_left_d = take_total - take_hdr;
					phase_d      = PH_RESP;
				end
			end

			// error: report now or discard the rest of the frame first
			if (do_fail) begin
				if (bytes_left_d == '0) begin
					phase_d            = PH_IDLE;
					emit               = 1'b1;
					res_d.done_res     = 1'b1;
					res_d.status       = fail_st;
					res_d.remote_error = (fail_st == ST_REMOTE) ? fail_rc : 8'd0;
				end else begin
					pend_d   = fail_st;
					remote_d = fail_rc;
					phase_d  = PH_DISCARD;
				end
			end

			// payload over: trailer next, or success
			if (do_after) begin
				if (present_d) begin
					phase_d   = PH_CRC;
					crc_idx_d = '0;
					crc_rx_d  = '0;
					if (after_pv) begin
						emit                = 1'b1;
						res_d.payload_valid = 1'b1;
						res_d.payload_byte  = after_pb;
					end
				end else begin
					phase_d               = PH_IDLE;
					emit                  = 1'b1;
					res_d.payload_valid   = after_pv;
					res_d.payload_byte    = after_pb;
					res_d.done_res        = 1'b1;
					res_d.received_length = plen_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			op_s1   <= rx.op;
			byte_s1 <= rx.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bytes_left_q <= '0;
			length_low_q <= '0;
			crc_q        <= CRC_INIT;
			crc_rx_q     <= '0;
			crc_idx_q    <= '0;
			tick_q       <= '0;
			present_q    <= 1'b0;
			pend_q       <= ST_OK;
			remote_q     <= '0;
			plen_q       <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (step) begin
				phase_q      <= phase_d;
				bytes_left_q <= bytes_left_d;
				length_low_q <= length_low_d;
				crc_q        <= crc_d;
				crc_rx_q     <= crc_rx_d;
				crc_idx_q    <= crc_idx_d;
				tick_q       <= tick_d;
				present_q    <= present_d;
				pend_q       <= pend_d;
				remote_q     <= remote_d;
				plen_q       <= plen_d;
			end
			if (adv) res_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) res_q <= res_d;
	end

	assign result.valid           = res_valid_q;
	assign result.payload_valid   = res_q.payload_valid;
	assign result.payload_byte    = res_q.payload_byte;
	assign result.done_res        = res_q.done_res;
	assign result.status          = res_q.status;
	assign result.remote_error    = res_q.remote_error;
	assign result.received_length = res_q.received_length;
endmodule

>>> rtl/response_frame_receiver_top.sv
// response_frame_receiver_top: top level of the response frame receiver
// depends on rfr_pkg, rfr_in_if, rfr_out_if, rfr_cfg, rfr_core
//
// usage
//   rx carries items: op start opens a frame, op byte delivers one serial byte,
//   op tick is the millisecond time base. a start while a frame is open drops it
//   result carries at most one item per rx item: a payload byte, a frame end
//   with status, or both on the last byte of a frame without trailer
//   cfg_we/cfg_idx/cfg_wdata write the five registers; write only while idle
// timing
//   an rx item sits one cycle in the input register, then its result (if any)
//   is in the result register: one cycle from rx accept to result valid
//   one rx item per cycle sustained; the crc-32 byte update and the frame state
//   machine each finish in the single cycle between the two registers
// stall
//   while result is held by a low ready, the input register keeps its item and
//   rx.ready drops only once that register is full too
// reset
//   arst_n clears all control state, frame idle, registers to their defaults

module response_frame_receiver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rfr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rfr_pkg::CFG_W-1:0]     cfg_wdata,
	rfr_in_if.sink                        rx,
	rfr_out_if.source                     result
);
	import rfr_pkg::*;

	cfg_t cfg;

	// register file, read by the state machine every cycle
	rfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// frame parser with its input and result registers
	rfr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.result (result)
	);
endmodule

>>> rtl/rfr_checker.sv
// rfr_checker: port level assertions for the response frame receiver, bound to the top
// depends on rfr_pkg and response_frame_receiver_top

module rfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        payload_valid,
	input logic [7:0]  payload_byte,
	input logic        done_res,
	input logic [3:0]  status,
	input logic [7:0]  remote_error,
	input logic [15:0] received_length
);
	import rfr_pkg::*;

	// every result item carries a byte or a frame end
	a_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (payload_valid || done_res))
		else $error("empty result item");

	// an error status only on a frame end without payload byte
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_OK) |-> (done_res && !payload_valid))
		else $error("error status outside a bare frame end");

	// remote byte reported only with remote status
	a_remote: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && remote_error != 8'd0) |-> (status == ST_REMOTE))
		else $error("remote byte without remote status");

	// a length only on a successful frame end
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && received_length != 16'd0) |-> (done_res && status == ST_OK))
		else $error("length outside a successful frame end");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(payload_byte)
			&& $stable(status) && $stable(done_res)))
		else $error("stalled result changed");
endmodule

bind response_frame_receiver_top rfr_checker u_rfr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.payload_valid   (result.payload_valid),
	.payload_byte    (result.payload_byte),
	.done_res        (result.done_res),
	.status          (result.status),
	.remote_error    (result.remote_error),
	.received_length (result.received_length)
);

>>> dv/tb_response_frame_receiver_top.sv
`timescale 1ns / 100ps
// tb_response_frame_receiver_top: self-checking bench for the response frame receiver,
// random frames with errors, ticks and restarts, checked against an in-bench predictor
// depends on rfr_pkg, rfr_in_if, rfr_out_if and response_frame_receiver_top

module tb_response_frame_receiver_top;
	import rfr_pkg::*;

	// expected-result bookkeeping: the frame parser's state, the register copy and
	// the queue of results still owed by the block
	class frame_checker;
		cfg_t        cfg;
		phase_t      ph;
		int unsigned left;
		logic [7:0]  len_lo;
		logic [31:0] crc_acc;
		logic [31:0] crc_rx;
		int unsigned crc_idx;
		logic [15:0] ticks;
		bit          has_crc;
		status_t     pend;
		logic [7:0]  rcode;
		logic [15:0] plen_acc;
		res_t        expected_results[$];
		int          mismatches;

		function new();
			cfg.rx_capacity = 16'd0;
			cfg.timeout_ticks = 16'd1000;
			cfg.ext_size_code = 7'd127;
			cfg.crc_resp_char = 8'd254;
			cfg.plain_resp_char = 8'd255;
			ph = PH_IDLE;
			mismatches = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			left = 0;
			len_lo = 8'h00;
			crc_acc = CRC_INIT;
			crc_rx = 32'h0;
			crc_idx = 0;
			ticks = 16'h0;
			has_crc = 1'b0;
			pend = ST_OK;
			rcode = 8'h00;
			plen_acc = 16'h0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_RX_CAPACITY:     cfg.rx_capacity = v;
				REG_TIMEOUT_TICKS:   cfg.timeout_ticks = v;
				REG_EXT_SIZE_CODE:   cfg.ext_size_code = v[6:0];
				REG_CRC_RESP_CHAR:   cfg.crc_resp_char = v[7:0];
				REG_PLAIN_RESP_CHAR: cfg.plain_resp_char = v[7:0];
				default: ;
			endcase
		endfunction

		// reflected crc-32, data bits taken lsb first
		function logic [31:0] crc_step(logic [31:0] c, logic [7:0] d);
			bit fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ d[i];
				c = c >> 1;
				if (fb)
					c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function bit busy();
			return expected_results.size() != 0;
		endfunction

		function void push(bit pv, logic [7:0] pb, bit done, status_t st, logic [7:0] re,
			logic [15:0] len);
			res_t r;
			r.payload_valid = pv;
			r.payload_byte = pb;
			r.done_res = done;
			r.status = st;
			r.remote_error = re;
			r.received_length = len;
			expected_results.push_back(r);
		endfunction

		// error: report now if the frame is used up, else swallow the rest first
		function void abort(status_t st, logic [7:0] rc);
			if (left == 0) begin
				ph = PH_IDLE;
				push(1'b0, 8'h00, 1'b1, st, st == ST_REMOTE ? rc : 8'h00, 16'h0);
			end else begin
				pend = st;
				rcode = rc;
				ph = PH_DISCARD;
			end
		endfunction

		function void finish_payload(bit pv, logic [7:0] pb);
			if (has_crc) begin
				ph = PH_CRC;
				crc_idx = 0;
				crc_rx = 32'h0;
				if (pv)
					push(1'b1, pb, 1'b0, ST_OK, 8'h00, 16'h0);
			end else begin
				ph = PH_IDLE;
				push(pv, pb, 1'b1, ST_OK, 8'h00, plen_acc);
			end
		endfunction

		function void set_size(int unsigned total, int unsigned hdr);
			if (total < hdr + 1) begin
				left = 0;
				abort(ST_TOO_SMALL, 8'h00);
			end else begin
				left = total - hdr;
				ph = PH_RESP;
			end
		endfunction

		// advances the parser by one accepted item; returns 0 for items it ignores
		function bit note_input(op_t op, logic [7:0] b);
			int unsigned data;
			int unsigned plen;
			status_t st;
			if (op == OP_START) begin
				clear_frame();
				ph = PH_SIZE;
				return 1'b1;
			end
			if (ph == PH_IDLE || op == OP_NONE)
				return 1'b0;
			if (op == OP_TICK) begin
				if (ticks != 16'hFFFF)
					ticks++;
				if (ticks >= cfg.timeout_ticks) begin
					st = (ph == PH_DISCARD) ? pend : ST_TIMEOUT;
					ph = PH_IDLE;
					push(1'b0, 8'h00, 1'b1, st, st == ST_REMOTE ? rcode : 8'h00, 16'h0);
				end
				return 1'b1;
			end
			if (ph inside {PH_SIZE, PH_EXT_LO, PH_EXT_HI, PH_RESP, PH_REMOTE, PH_PAYLOAD})
				crc_acc = crc_step(crc_acc, b);
			case (ph)
				PH_SIZE: begin
					if (!b[0]) begin
						left = 0;
						abort(ST_BAD_FIRST, 8'h00);
					end else if (b[7:1] == cfg.ext_size_code) begin
						ph = PH_EXT_LO;
					end else begin
						set_size(b[7:1], 1);
					end
				end
				PH_EXT_LO: begin
					len_lo = b;
					ph = PH_EXT_HI;
				end
				PH_EXT_HI: set_size({b, len_lo}, 3);
				PH_RESP: begin
					left--;
					if (b == cfg.crc_resp_char) begin
						has_crc = 1'b1;
						if (left < 4) begin
							abort(ST_TOO_SMALL, 8'h00);
							return 1'b1;
						end
						data = left - 4;
					end else if (b == cfg.plain_resp_char) begin
						has_crc = 1'b0;
						data = left;
					end else begin
						abort(ST_BAD_CHAR, 8'h00);
						return 1'b1;
					end
					if (data != 0) begin
						ph = PH_REMOTE;
					end else if (cfg.rx_capacity != 16'h0) begin
						abort(ST_WRONG_SIZE, 8'h00);
					end else begin
						plen_acc = 16'h0;
						finish_payload(1'b0, 8'h00);
					end
				end
				PH_REMOTE: begin
					left--;
					plen = left - (has_crc ? 4 : 0);
					if (b != 8'h00) begin
						abort(ST_REMOTE, b);
					end else if (plen > cfg.rx_capacity) begin
						abort(ST_CAPACITY, 8'h00);
					end else begin
						plen_acc = plen[15:0];
						if (plen == 0)
							finish_payload(1'b0, 8'h00);
						else
							ph = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					left--;
					if (left == (has_crc ? 4 : 0))
						finish_payload(1'b1, b);
					else
						push(1'b1, b, 1'b0, ST_OK, 8'h00, 16'h0);
				end
				PH_CRC: begin
					crc_rx = crc_rx | ({24'h0, b} << (8 * crc_idx));
					if (left > 0)
						left--;
					if (crc_idx < 3) begin
						crc_idx++;
					end else begin
						crc_idx = 0;
						ph = PH_IDLE;
						if ((crc_acc ^ CRC_INIT) != crc_rx)
							push(1'b0, 8'h00, 1'b1, ST_CRC, 8'h00, 16'h0);
						else
							push(1'b0, 8'h00, 1'b1, ST_OK, 8'h00, plen_acc);
					end
				end
				PH_DISCARD: begin
					if (left > 0)
						left--;
					if (left == 0) begin
						ph = PH_IDLE;
						push(1'b0, 8'h00, 1'b1, pend, pend == ST_REMOTE ? rcode : 8'h00,
							16'h0);
					end
				end
				default: ph = PH_IDLE;
			endcase
			return 1'b1;
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: pv=%0d byte=%02h done=%0d st=%0d re=%02h len=%0d",
						got.payload_valid, got.payload_byte, got.done_res, got.status,
						got.remote_error, got.received_length);
				return;
			end
			want = expected_results.pop_front();
			if (got.payload_valid !== want.payload_valid || got.payload_byte !== want.payload_byte ||
				got.done_res !== want.done_res || got.status !== want.status ||
				got.remote_error !== want.remote_error ||
				got.received_length !== want.received_length) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result mismatch at %0t", $realtime);
					$display("  expected pv=%0d byte=%02h done=%0d st=%0d re=%02h len=%0d",
						want.payload_valid, want.payload_byte, want.done_res, want.status,
						want.remote_error, want.received_length);
					$display("  actual   pv=%0d byte=%02h done=%0d st=%0d re=%02h len=%0d",
						got.payload_valid, got.payload_byte, got.done_res, got.status,
						got.remote_error, got.received_length);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	rfr_in_if  rx_if ();
	rfr_out_if res_if ();

	response_frame_receiver_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_if),
		.result    (res_if)
	);

	frame_checker sb;

	// idle percentages per side, tick density inside frames
	int src_idle_pct;
	int snk_idle_pct;
	int frame_tick_pct;
	// items that moved the parser (ignored ones are not counted)
	int accepted_items;
	// each increment asks the result side for one long hold-off
	int hold_req;
	int hold_done;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("tb_response_frame_receiver_top: done, errors");
		$finish;
	end

	// result side: random stalls, plus a counted long hold-off on request
	initial begin
		res_if.ready <= 1'b0;
		hold_done = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (hold_req != hold_done) begin
				// long stall: the block should fill up and drop rx ready
				hold_done = hold_req;
				hold_left = 400;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// every accepted input item goes through the predictor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rx_if.valid && rx_if.ready) begin
			if (sb.note_input(op_t'(rx_if.op), rx_if.byte_value))
				accepted_items++;
		end
	end

	// every accepted result item is checked against the oldest expectation
	always @(posedge clk) begin : result_mon
		res_t got;
		if (arst_n === 1'b1 && res_if.valid && res_if.ready) begin
			got.payload_valid = res_if.payload_valid;
			got.payload_byte = res_if.payload_byte;
			got.done_res = res_if.done_res;
			got.status = res_if.status;
			got.remote_error = res_if.remote_error;
			got.received_length = res_if.received_length;
			sb.check_result(got);
		end
	end

	// one item on rx; random gaps before it, returns at the accepting edge
	task automatic send_item(op_t op, logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.op <= op;
		rx_if.byte_value <= b;
		do
			@(posedge clk);
		while (!rx_if.ready);
	endtask

	// start item, then the frame bytes with a tick now and then
	task automatic send_frame(input logic [7:0] q[$]);
		send_item(OP_START, 8'($urandom_range(255)));
		foreach (q[i]) begin
			if ($urandom_range(99) < frame_tick_pct)
				send_item(OP_TICK, 8'($urandom_range(255)));
			send_item(OP_BYTE, q[i]);
		end
	endtask

	// appends the little-endian crc-32 of everything already in the frame
	function automatic void add_trailer(ref logic [7:0] q[$]);
		logic [31:0] c;
		c = CRC_INIT;
		foreach (q[i])
			c = sb.crc_step(c, q[i]);
		c = ~c;
		for (int k = 0; k < 4; k++)
			q.push_back(c[8*k +: 8]);
	endfunction

	// random frame for the current settings; most are well formed, some carry
	// one fault: capacity, remote error, bad first byte, bad char, crc,
	// short size, size off by one, truncation or a huge announced size
	task automatic build_frame(output logic [7:0] q[$]);
		int unsigned cap;
		int unsigned plen;
		int unsigned len;
		int unsigned total;
		int unsigned kind;
		int unsigned hdr;
		int unsigned cut;
		bit          use_crc;
		bit          use_ext;
		bit          has_data;
		logic [7:0]  ext_byte;
		logic [7:0]  resp;
		cap = sb.cfg.rx_capacity;
		kind = $urandom_range(99);
		use_crc = 1'($urandom_range(1));
		resp = use_crc ? sb.cfg.crc_resp_char : sb.cfg.plain_resp_char;
		ext_byte = {sb.cfg.ext_size_code, 1'b1};
		plen = $urandom_range(cap < 12 ? cap : 12);
		// payload over capacity
		if (kind < 8 && cap < 60)
			plen = cap + $urandom_range(3, 1);
		has_data = (plen != 0) || $urandom_range(1);
		q = {};
		// huge announced size: a few bytes only, the next start drops it
		if (kind >= 46 && kind < 48) begin
			q = {ext_byte, 8'hFF, 8'hFF, resp, 8'h00};
			repeat ($urandom_range(4))
				q.push_back(8'($urandom_range(255)));
			return;
		end
		len = 1 + (has_data ? 1 + plen : 0) + (use_crc ? 4 : 0);
		use_ext = ($urandom_range(9) == 0) || (len + 1 > 127) ||
			(len + 1 == sb.cfg.ext_size_code);
		if (use_ext) begin
			total = len + 3;
			hdr = 3;
			q.push_back(ext_byte);
			q.push_back(total[7:0]);
			q.push_back(total[15:8]);
		end else begin
			total = len + 1;
			hdr = 1;
			q.push_back({total[6:0], 1'b1});
		end
		q.push_back(resp);
		if (has_data) begin
			// remote error byte, nonzero for a slice of the frames
			q.push_back((kind >= 8 && kind < 16) ? 8'($urandom_range(255, 1)) : 8'h00);
			repeat (plen)
				q.push_back(8'($urandom_range(255)));
		end
		if (use_crc)
			add_trailer(q);
		if (kind >= 16 && kind < 46) begin
			case ((kind - 16) / 5)
				0: q[0][0] = 1'b0;
				1: q[hdr] = 8'($urandom_range(255));
				2: begin
					if (use_crc)
						q[q.size() - 1 - $urandom_range(3)] ^= 8'($urandom_range(255, 1));
				end
				3: begin
					// size below the header plus the response character
					if (use_ext) begin
						q[1] = 8'($urandom_range(3));
						q[2] = 8'h00;
					end else begin
						q[0] = {6'd0, 1'($urandom_range(1)), 1'b1};
					end
				end
				4: begin
					if (!use_ext)
						q[0] = q[0] + ($urandom_range(1) ? 8'd2 : 8'hFE);
				end
				default: begin
					cut = $urandom_range(q.size() - 1);
					while (q.size() > cut)
						void'(q.pop_back());
				end
			endcase
		end
	endtask

	// register writes, one per cycle; only called with nothing in flight
	task automatic apply_config(logic [15:0] cap, logic [15:0] tmo, logic [6:0] ext,
		logic [7:0] crc_char, logic [7:0] plain_char);
		reg_idx_t    regs[5];
		logic [15:0] vals[5];
		regs = '{REG_RX_CAPACITY, REG_TIMEOUT_TICKS, REG_EXT_SIZE_CODE,
			REG_CRC_RESP_CHAR, REG_PLAIN_RESP_CHAR};
		vals = '{cap, tmo, {9'd0, ext}, {8'd0, crc_char}, {8'd0, plain_char}};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= regs[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// random settings, extremes picked often
	task automatic pick_config();
		logic [15:0] cap;
		logic [15:0] tmo;
		logic [6:0]  ext;
		logic [7:0]  crc_char;
		logic [7:0]  plain_char;
		case ($urandom_range(3))
			0: cap = 16'h0000;
			1: cap = 16'hFFFF;
			2: cap = 16'($urandom_range(65535));
			default: cap = 16'($urandom_range(20));
		endcase
		case ($urandom_range(4))
			0: tmo = 16'd1;
			1: tmo = 16'hFFFF;
			2: tmo = 16'($urandom_range(8, 1));
			3: tmo = 16'd1000;
			default: tmo = 16'($urandom_range(65535, 1));
		endcase
		case ($urandom_range(2))
			0: ext = 7'd0;
			1: ext = 7'd127;
			default: ext = 7'($urandom_range(127));
		endcase
		case ($urandom_range(2))
			0: crc_char = 8'h00;
			1: crc_char = 8'hFF;
			default: crc_char = 8'($urandom_range(255));
		endcase
		plain_char = 8'($urandom_range(255));
		// equal characters now and then, the crc one should win
		if ($urandom_range(7) == 0)
			plain_char = crc_char;
		apply_config(cap, tmo, ext, crc_char, plain_char);
	endtask

	// stop offering, wait out all owed results, then let the pipe settle
	task automatic drain();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.busy())
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// batches of random frames and noise, new settings for each batch
	task automatic run_phase(int n_batches);
		logic [7:0] q[$];
		int         target;
		repeat (n_batches) begin
			pick_config();
			frame_tick_pct = $urandom_range(12);
			target = accepted_items + 130;
			while (accepted_items < target) begin
				if ($urandom_range(9) == 0) begin
					// noise: any op, including the unused one and stray bytes
					send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
				end else begin
					build_frame(q);
					send_frame(q);
				end
			end
			drain();
		end
	endtask

	initial begin
		logic [7:0] q[$];
		rx_if.valid <= 1'b0;
		rx_if.op <= OP_NONE;
		rx_if.byte_value <= 8'h00;
		cfg_we <= 1'b0;
		cfg_idx <= REG_RX_CAPACITY;
		cfg_wdata <= 16'h0000;
		arst_n <= 1'b0;
		sb = new();
		accepted_items = 0;
		hold_req = 0;
		src_idle_pct = 19;
		snk_idle_pct = 45;
		frame_tick_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: small capacity, default timeout, size code and characters
		apply_config(16'd8, 16'd1000, 7'd127, 8'd254, 8'd255);
		// tick and the unused op while idle: ignored
		send_item(OP_TICK, 8'h00);
		send_item(OP_NONE, 8'hFF);
		// plain frame, two payload bytes at both extremes
		send_frame('{8'h0B, 8'hFF, 8'h00, 8'h00, 8'hFF});
		// crc frame with one payload byte
		q = '{8'h11, 8'hFE, 8'h00, 8'hA5};
		add_trailer(q);
		send_frame(q);
		// even size byte
		send_frame('{8'h02});
		// extended size, plain with no data while capacity is nonzero
		send_frame('{8'hFF, 8'h04, 8'h00, 8'hFF});
		drain();

		// sender idles less than the receiver, one long hold-off early on
		hold_req++;
		run_phase(5);
		// the other way round
		src_idle_pct = 45;
		snk_idle_pct = 19;
		run_phase(5);
		// no idling at all, apart from one more long hold-off
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req++;
		run_phase(5);

		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && !sb.busy())
			$display("tb_response_frame_receiver_top: done, clean");
		else
			$display("tb_response_frame_receiver_top: done, errors");
		$finish;
	end

endmodule
